/* hw/rtl/gyro_motion_deadzone_unit_assert.svh */
// Assertion macros for the gyro motion deadzone unit.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef GYRO_MOTION_DEADZONE_UNIT_ASSERT_SVH
`define GYRO_MOTION_DEADZONE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GMD_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("gmd: forbidden condition seen");
`define GMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmd: expected follow-up missing");
`else
`define GMD_ASSERT_NEVER(label, expr)
`define GMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/gmd_pkg.sv */
// Shared types for the gyro motion deadzone unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package gmd_pkg;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic               enabled;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_t;

  typedef struct packed {
    logic               updated;
    logic signed [15:0] axial_dx;
    logic signed [15:0] axial_dy;
    logic signed [15:0] radial_dx;
    logic signed [15:0] radial_dy;
  } out_t;

  typedef struct packed {
    logic [15:0] sensitivity;
    logic [2:0]  invert_mask;
    logic [1:0]  bind_mode;
    logic [30:0] deadzone;
    logic [30:0] min_step;
    logic [31:0] delay_ms;
  } cfg_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic               upd;
    logic [31:0]        dt;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } job_t;

endpackage

/* hw/rtl/gmd_front.sv */
// Front end: accepts samples, tracks the last accepted timestamp and decides
// whether a sample replaces the stored motion. Depends on gmd_pkg.
`timescale 1ns / 1ps
module gmd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gmd_pkg::in_t       sample,
  output logic               full,
  input  logic [31:0]        delay_ms,
  output logic               q_push,
  output gmd_pkg::job_t      q_data,
  input  logic               q_full
);

  logic [31:0] last_time;
  logic [31:0] dt;
  logic        upd;

  assign dt     = sample.time_ms - last_time;
  assign upd    = sample.enabled && (dt > delay_ms);
  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data.upd    = upd;
    q_data.dt     = dt;
    q_data.rate_x = sample.rate_x;
    q_data.rate_y = sample.rate_y;
    q_data.rate_z = sample.rate_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (q_push && upd) begin
      last_time <= sample.time_ms;
    end
  end

endmodule

/* hw/rtl/gmd_queue.sv */
// Two-entry queue between the front and the back end.
// Depends on gmd_pkg for the entry type.
`timescale 1ns / 1ps
module gmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gmd_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output gmd_pkg::job_t dout,
  output logic          empty
);

  gmd_pkg::job_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/gmd_back.sv */
// Back end: scales accepted samples into stored motion and computes the axial
// and radial views with one shared multiplier, divider and square root.
// Depends on gmd_pkg.
`timescale 1ns / 1ps
module gmd_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  gmd_pkg::cfg_t cfg,
  input  gmd_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_pop,
  output gmd_pkg::out_t result,
  output logic          empty,
  input  logic          pop,
  output logic          busy
);

  localparam int NUMW = 64 + FRACTION_BITS;
  localparam int CNTW = $clog2(NUMW + 1);
  localparam int SHR  = (FRACTION_BITS >= 14) ? FRACTION_BITS - 14 : 0;
  localparam int SHL  = (FRACTION_BITS < 14) ? 14 - FRACTION_BITS : 0;
  localparam int SC_SHL = (FRACTION_BITS >= 11) ? FRACTION_BITS - 11 : 0;
  localparam int SC_SHR = (FRACTION_BITS < 11) ? 11 - FRACTION_BITS : 0;
  localparam logic [63:0] ONE2      = 64'(1) << (2 * FRACTION_BITS);
  localparam logic [63:0] RECIP     = 64'd18446744073709552;
  localparam logic [76:0] SAT_N     = 77'(125) << 47;
  localparam logic [1:0]  BIND_Z    = 2'd1;
  localparam logic [1:0]  BIND_XZ   = 2'd2;
  localparam logic [47:0] POS_LIM   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIM   = 48'h8000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_SC_M1, S_SC_M2, S_SC_LD, S_SC_P0, S_SC_P1, S_SC_P2, S_SC_P3,
    S_SC_ACC, S_SC_FIN,
    S_H, S_RSH, S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_CLS, S_SQRT,
    S_RD_M, S_RD_LD, S_RD_DIV, S_RD_FIN, S_DONE
  } state_t;

  state_t                state;
  gmd_pkg::job_t         job_r;
  logic [1:0]            axis;
  logic signed [47:0]    motion_x, motion_y, motion_z;
  logic [63:0]           prod;
  logic [NUMW-1:0]       num;
  logic [31:0]           rem, den;
  logic [47:0]           quo;
  logic                  ovf;
  logic [53:0]           scn;
  logic [111:0]          acc, acc_sum;
  logic [76:0]           sc_num;
  logic [CNTW-1:0]       cnt;
  logic [48:0]           ah, av;
  logic                  nh, nv, big, norm, comp;
  logic [63:0]           sq, dz2;
  logic [63:0]           sq_n, sq_res, sq_bit;
  logic [31:0]           len;
  logic [39:0]           rh, rv;
  logic [15:0]           ax_dx, ax_dy;
  logic                  out_valid;

  function automatic logic [15:0] axial_f(input logic [48:0] v, input logic [30:0] dz,
                                          input logic [30:0] md);
    logic        neg;
    logic [48:0] mag, tm, ip, r;
    neg = v[48];
    mag = neg ? -v : v;
    ip  = mag >> FRACTION_BITS;
    tm  = ip << FRACTION_BITS;
    if (tm < 49'(dz)) begin
      r = '0;
    end else begin
      if (tm < 49'(md)) begin
        ip = 49'(md >> FRACTION_BITS);
      end
      r = (ip > 49'd32767) ? 49'd32767 : ip;
    end
    return neg ? 16'(-r) : 16'(r);
  endfunction

  function automatic logic [39:0] to_q14(input logic [39:0] m);
    return (m >> SHR) << SHL;
  endfunction

  function automatic logic [15:0] sat_q14(input logic neg, input logic [39:0] m);
    logic [15:0] r;
    if (neg) begin
      r = (m > 40'd32768) ? 16'h8000 : 16'(-m);
    end else begin
      r = (m > 40'd32767) ? 16'h7FFF : m[15:0];
    end
    return r;
  endfunction

  // Axis being scaled.
  logic signed [15:0] rate_sel;
  logic signed [16:0] r17;
  logic [16:0]        mag_r;
  logic               sc_neg;
  logic [47:0]        sc_lim, sc_q, sc_val;

  always_comb begin
    case (axis)
      2'd0:    rate_sel = job_r.rate_x;
      2'd1:    rate_sel = job_r.rate_y;
      default: rate_sel = job_r.rate_z;
    endcase
    r17    = {rate_sel[15], rate_sel};
    mag_r  = r17[16] ? 17'(-r17) : 17'(r17);
    sc_neg = rate_sel[15] ^ cfg.invert_mask[axis];
    sc_lim = sc_neg ? NEG_LIM : POS_LIM;
    sc_q   = (ovf || quo > sc_lim) ? sc_lim : quo;
    sc_val = sc_neg ? -sc_q : sc_q;
  end

  // Scaling divides by 1000 ms times 256 = 2^11 * 125. The power of two is a
  // shift; the 125 is a reciprocal multiplication, exact for numerators below
  // 2^54, and any larger numerator saturates the stored value anyway.
  assign sc_num = (77'(prod) << SC_SHL) >> SC_SHR;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [30:0] comp_mag;

  assign comp_mag = comp ? av[30:0] : ah[30:0];

  always_comb begin
    case (state)
      S_SC_M1: begin mul_a = 32'(mag_r);       mul_b = 32'(cfg.sensitivity); end
      S_SC_M2: begin mul_a = prod[31:0];       mul_b = job_r.dt; end
      S_SC_P0: begin mul_a = scn[31:0];        mul_b = RECIP[31:0]; end
      S_SC_P1: begin mul_a = scn[31:0];        mul_b = RECIP[63:32]; end
      S_SC_P2: begin mul_a = 32'(scn[53:32]);  mul_b = RECIP[31:0]; end
      S_SC_P3: begin mul_a = 32'(scn[53:32]);  mul_b = RECIP[63:32]; end
      S_SQ1:   begin mul_a = {1'b0, ah[30:0]}; mul_b = {1'b0, ah[30:0]}; end
      S_SQ2:   begin mul_a = {1'b0, av[30:0]}; mul_b = {1'b0, av[30:0]}; end
      S_SQ3:   begin mul_a = {1'b0, cfg.deadzone}; mul_b = {1'b0, cfg.deadzone}; end
      S_SQ4:   begin mul_a = {1'b0, cfg.min_step}; mul_b = {1'b0, cfg.min_step}; end
      S_RD_M:  begin mul_a = {1'b0, comp_mag}; mul_b = {1'b0, cfg.min_step}; end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Reciprocal partial products are taken from the registered prod.
  always_comb begin
    case (state)
      S_SC_P2, S_SC_P3: acc_sum = acc + (112'(prod) << 32);
      S_SC_ACC:         acc_sum = acc + (112'(prod) << 64);
      default:          acc_sum = 112'(prod);
    endcase
  end

  // Restoring divider step, one quotient bit per cycle.
  logic [32:0] div_t;
  logic        div_ge;
  logic [31:0] div_r;

  assign div_t  = {rem, num[NUMW-1]};
  assign div_ge = div_t >= {1'b0, den};
  assign div_r  = div_ge ? 32'(div_t - {1'b0, den}) : div_t[31:0];

  // Square root step, two radicand bits per cycle.
  logic [63:0] sq_try, sq_res_next;
  logic        sq_ge;

  assign sq_try      = sq_res + sq_bit;
  assign sq_ge       = sq_n >= sq_try;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  // Horizontal source and vertical value, sign extended.
  logic signed [48:0] mx49, my49, mz49, h_c;

  always_comb begin
    mx49 = {motion_x[47], motion_x};
    my49 = {motion_y[47], motion_y};
    mz49 = {motion_z[47], motion_z};
    case (cfg.bind_mode)
      BIND_Z:  h_c = mz49;
      BIND_XZ: h_c = mx49 + mz49;
      default: h_c = mx49;
    endcase
  end

  logic [39:0] rd_val;
  assign rd_val = norm ? quo[39:0] : to_q14(quo[39:0]);

  assign job_pop = (state == S_IDLE) && !job_empty;
  assign busy    = (state != S_IDLE);
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      motion_x  <= '0;
      motion_y  <= '0;
      motion_z  <= '0;
    end else begin
      if (pop && out_valid && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job_r <= job;
            axis  <= 2'd0;
            state <= job.upd ? S_SC_M1 : S_H;
          end
        end
        S_SC_M1: state <= S_SC_M2;
        S_SC_M2: state <= S_SC_LD;
        S_SC_LD: begin
          ovf   <= (sc_num >= SAT_N);
          scn   <= sc_num[53:0];
          state <= S_SC_P0;
        end
        S_SC_P0: state <= S_SC_P1;
        S_SC_P1: begin
          acc   <= acc_sum;
          state <= S_SC_P2;
        end
        S_SC_P2: begin
          acc   <= acc_sum;
          state <= S_SC_P3;
        end
        S_SC_P3: begin
          acc   <= acc_sum;
          state <= S_SC_ACC;
        end
        S_SC_ACC: begin
          quo   <= acc_sum[108:61];
          state <= S_SC_FIN;
        end
        S_RD_DIV: begin
          num <= num << 1;
          rem <= div_r;
          quo <= {quo[46:0], div_ge};
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= S_RD_FIN;
          end
        end
        S_SC_FIN: begin
          case (axis)
            2'd0:    motion_x <= sc_val;
            2'd1:    motion_y <= sc_val;
            default: motion_z <= sc_val;
          endcase
          if (axis == 2'd2) begin
            state <= S_H;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_SC_M1;
          end
        end
        S_H: begin
          ax_dx <= axial_f(h_c, cfg.deadzone, cfg.min_step);
          ax_dy <= axial_f(my49, cfg.deadzone, cfg.min_step);
          ah    <= h_c[48] ? 49'(-h_c) : 49'(h_c);
          av    <= my49[48] ? 49'(-my49) : 49'(my49);
          nh    <= h_c[48];
          nv    <= my49[48];
          big   <= 1'b0;
          state <= S_RSH;
        end
        S_RSH: begin
          // Halve oversized vectors until both components fit in 31 bits.
          if ((|ah[48:31]) || (|av[48:31])) begin
            ah  <= ah >> 1;
            av  <= av >> 1;
            big <= 1'b1;
          end else begin
            state <= S_SQ1;
          end
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin
          sq    <= prod;
          state <= S_SQ3;
        end
        S_SQ3: begin
          sq    <= sq + prod;
          state <= S_SQ4;
        end
        S_SQ4: begin
          dz2   <= prod;
          state <= S_CLS;
        end
        S_CLS: begin
          // prod now holds min_step squared.
          sq_n   <= sq;
          sq_res <= '0;
          sq_bit <= 64'(1) << 62;
          if (!big && sq < dz2) begin
            rh    <= '0;
            rv    <= '0;
            state <= S_DONE;
          end else if (!big && sq < prod) begin
            norm <= 1'b0;
            if (sq == 64'd0) begin
              rh    <= '0;
              rv    <= '0;
              state <= S_DONE;
            end else begin
              state <= S_SQRT;
            end
          end else if (big || sq > ONE2) begin
            norm  <= 1'b1;
            state <= S_SQRT;
          end else begin
            rh    <= to_q14({9'b0, ah[30:0]});
            rv    <= to_q14({9'b0, av[30:0]});
            state <= S_DONE;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n <= sq_n - sq_try;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            len   <= sq_res_next[31:0];
            comp  <= 1'b0;
            state <= S_RD_M;
          end
        end
        S_RD_M: state <= S_RD_LD;
        S_RD_LD: begin
          num   <= norm ? NUMW'({comp_mag, 14'b0}) : NUMW'(prod);
          den   <= len;
          rem   <= '0;
          quo   <= '0;
          cnt   <= CNTW'(NUMW);
          state <= S_RD_DIV;
        end
        S_RD_FIN: begin
          if (comp) begin
            rv    <= rd_val;
            state <= S_DONE;
          end else begin
            rh    <= rd_val;
            comp  <= 1'b1;
            state <= S_RD_M;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            result.updated   <= job_r.upd;
            result.axial_dx  <= ax_dx;
            result.axial_dy  <= ax_dy;
            result.radial_dx <= sat_q14(nh, rh);
            result.radial_dy <= sat_q14(nv, rv);
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/gyro_motion_deadzone_unit.sv */
// Gyro motion deadzone unit: top level with the configuration registers.
// Depends on gmd_pkg, gmd_front, gmd_queue, gmd_back and the assertion header.
//
// Samples enter through push/full and results leave through empty/pop; each
// sample gives exactly one result, in order. A sample that is enabled and whose
// wrapped elapsed time exceeds delay_ms replaces the stored three-axis motion.
// Registers sit on an APB-style port at byte addresses 4*i; pready is always high.
// The processing time of a sample is set by the shared bit-serial divider,
// which works on N = 64 + FRACTION_BITS (80 by default) numerator bits, and
// by the square root of the back end. It grows when the motion is replaced,
// when the radial vector is stretched or normalized, and with each halving
// of an oversized vector (at most 18 halvings).
// The back end takes a new sample only once it has finished the last; up to
// two further samples wait in the queue behind the front end while the back
// end works.
// Reset clears the stored motion, the last timestamp and all queues, and loads
// the register defaults. A stalled receiver holds the finished result on the
// result ports; the back end then waits and the queue fills until full rises.
`timescale 1ns / 1ps
`include "gyro_motion_deadzone_unit_assert.svh"
module gyro_motion_deadzone_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  gmd_pkg::in_t  sample,
  output logic          empty,
  input  logic          pop,
  output gmd_pkg::out_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic [2:0] REG_SENS  = 3'd0;
  localparam logic [2:0] REG_INV   = 3'd1;
  localparam logic [2:0] REG_BIND  = 3'd2;
  localparam logic [2:0] REG_DZ    = 3'd3;
  localparam logic [2:0] REG_MD    = 3'd4;
  localparam logic [2:0] REG_DELAY = 3'd5;
  localparam logic [15:0] SENS_RESET = 16'd256;

  gmd_pkg::cfg_t cfg;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensitivity <= SENS_RESET;
      cfg.invert_mask <= '0;
      cfg.bind_mode   <= '0;
      cfg.deadzone    <= '0;
      cfg.min_step    <= '0;
      cfg.delay_ms    <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SENS:  cfg.sensitivity <= pwdata[15:0];
        REG_INV:   cfg.invert_mask <= pwdata[2:0];
        REG_BIND:  cfg.bind_mode   <= pwdata[1:0];
        REG_DZ:    cfg.deadzone    <= pwdata[30:0];
        REG_MD:    cfg.min_step    <= pwdata[30:0];
        REG_DELAY: cfg.delay_ms    <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SENS:  prdata = 32'(cfg.sensitivity);
      REG_INV:   prdata = 32'(cfg.invert_mask);
      REG_BIND:  prdata = 32'(cfg.bind_mode);
      REG_DZ:    prdata = 32'(cfg.deadzone);
      REG_MD:    prdata = 32'(cfg.min_step);
      REG_DELAY: prdata = cfg.delay_ms;
      default:   prdata = '0;
    endcase
  end

  gmd_pkg::job_t q_in, q_out;
  logic          q_push, q_full, q_pop, q_empty, busy;

  gmd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .full     (full),
    .delay_ms (cfg.delay_ms),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  gmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  gmd_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (q_out),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .busy      (busy)
  );

  // A request only leaves the queue when one is there, starts the back end,
  // and a result only appears after the back end has been working.
  `GMD_ASSERT_NEVER(a_pop_when_empty, q_pop && q_empty)
  `GMD_ASSERT_NEXT(a_job_starts, q_pop, busy)
  `GMD_ASSERT_NEVER(a_result_from_work, $fell(empty) && !$past(busy))

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the gyro motion deadzone unit.
// Depends on gmd_pkg and the gyro_motion_deadzone_unit top level.
`timescale 1ns / 1ps
module testbench;

  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 5000000;

  typedef enum int {
    REG_SENSITIVITY = 0,
    REG_INVERT_MASK = 1,
    REG_BIND_MODE   = 2,
    REG_DEADZONE    = 3,
    REG_MIN_STEP    = 4,
    REG_DELAY_MS    = 5
  } reg_idx_t;

  // Tracks the stored motion and the register settings, and keeps the
  // expected result of every accepted request in arrival order.
  class motion_tracker;
    gmd_pkg::cfg_t regs;
    logic [31:0]   last_time;
    longint        mot_x, mot_y, mot_z;
    gmd_pkg::out_t due_results[$];
    int            failures;

    function void reset_state();
      regs = '0;
      regs.sensitivity = 16'd256;
      last_time = '0;
      mot_x = 0;
      mot_y = 0;
      mot_z = 0;
      due_results.delete();
      failures = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_SENSITIVITY: regs.sensitivity = val[15:0];
        REG_INVERT_MASK: regs.invert_mask = val[2:0];
        REG_BIND_MODE:   regs.bind_mode = val[1:0];
        REG_DEADZONE:    regs.deadzone = val[30:0];
        REG_MIN_STEP:    regs.min_step = val[30:0];
        REG_DELAY_MS:    regs.delay_ms = val;
        default: ;
      endcase
    endfunction

    function longint scale(logic signed [15:0] rate, bit inv, logic [31:0] dt);
      longint sr;
      longint unsigned m, p, hi, rem, lim, q, dv;
      bit neg;
      sr = rate;
      neg = sr < 0;
      m = neg ? -sr : sr;
      dv = 64'd256000;
      p = m * longint'(regs.sensitivity) * longint'({32'd0, dt});
      hi = p / dv;
      rem = p % dv;
      if (inv) neg = !neg;
      lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
      if (hi >= (64'd1 << (47 - FB))) begin
        q = lim;
      end else begin
        q = (hi << FB) + ((rem << FB) / dv);
        if (q > lim) q = lim;
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function logic signed [15:0] axial(longint v);
      longint unsigned ip, tm;
      bit neg;
      neg = v < 0;
      ip = (neg ? -v : v);
      ip = ip >> FB;
      tm = ip << FB;
      if (tm < regs.deadzone) return 16'sd0;
      if (tm < regs.min_step) ip = regs.min_step >> FB;
      if (ip > 32767) ip = 32767;
      return neg ? -16'(ip) : 16'(ip);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic signed [15:0] sat14(bit neg, longint unsigned m);
      if (neg) return (m > 32768) ? -16'sd32768 : -16'(m);
      return (m > 32767) ? 16'sd32767 : 16'(m);
    endfunction

    function void radial(longint h, longint v,
                         output logic signed [15:0] oh, output logic signed [15:0] ov);
      longint unsigned ah, av, sq, len, rh, rv, dz, md;
      bit nh, nv, big;
      nh = h < 0;
      nv = v < 0;
      ah = nh ? -h : h;
      av = nv ? -v : v;
      big = 0;
      dz = regs.deadzone;
      md = regs.min_step;
      while (ah >= (64'd1 << 31) || av >= (64'd1 << 31)) begin
        ah = ah >> 1;
        av = av >> 1;
        big = 1;
      end
      sq = ah * ah + av * av;
      if (!big && sq < dz * dz) begin
        rh = 0;
        rv = 0;
      end else if (!big && sq < md * md) begin
        if (sq == 0) begin
          rh = 0;
          rv = 0;
        end else begin
          len = root(sq);
          rh = (ah * md / len) >> (FB - 14);
          rv = (av * md / len) >> (FB - 14);
        end
      end else if (big || sq > (64'd1 << (2 * FB))) begin
        len = root(sq);
        rh = (ah << 14) / len;
        rv = (av << 14) / len;
      end else begin
        rh = ah >> (FB - 14);
        rv = av >> (FB - 14);
      end
      oh = sat14(nh, rh);
      ov = sat14(nv, rv);
    endfunction

    function void note_sample(gmd_pkg::in_t s);
      logic [31:0] dt;
      longint hz;
      gmd_pkg::out_t r;
      dt = s.time_ms - last_time;
      r = '0;
      if (s.enabled && dt > regs.delay_ms) begin
        last_time = s.time_ms;
        mot_x = scale(s.rate_x, regs.invert_mask[0], dt);
        mot_y = scale(s.rate_y, regs.invert_mask[1], dt);
        mot_z = scale(s.rate_z, regs.invert_mask[2], dt);
        r.updated = 1'b1;
      end
      case (regs.bind_mode)
        2'd1: hz = mot_z;
        2'd2: hz = mot_x + mot_z;
        default: hz = mot_x;
      endcase
      r.axial_dx = axial(hz);
      r.axial_dy = axial(mot_y);
      radial(hz, mot_y, r.radial_dx, r.radial_dy);
      due_results.push_back(r);
    endfunction

    function void check_result(gmd_pkg::out_t got);
      gmd_pkg::out_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (got.updated !== want.updated) begin
        $error("updated: expected %0d, got %0d", want.updated, got.updated);
        failures++;
      end
      if (got.axial_dx !== want.axial_dx) begin
        $error("axial_dx: expected %0d, got %0d", want.axial_dx, got.axial_dx);
        failures++;
      end
      if (got.axial_dy !== want.axial_dy) begin
        $error("axial_dy: expected %0d, got %0d", want.axial_dy, got.axial_dy);
        failures++;
      end
      if (got.radial_dx !== want.radial_dx) begin
        $error("radial_dx: expected %0d, got %0d", want.radial_dx, got.radial_dx);
        failures++;
      end
      if (got.radial_dy !== want.radial_dy) begin
        $error("radial_dy: expected %0d, got %0d", want.radial_dy, got.radial_dy);
        failures++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  gmd_pkg::in_t  sample = '0;
  logic          empty;
  logic          pop = 1'b0;
  gmd_pkg::out_t result;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  motion_tracker tracker;
  logic [31:0]   now_ms = '0;
  bit            calm = 0;
  int            hold_off = 0;
  int            pop_stall = 0;
  int            cycles = 0;

  gyro_motion_deadzone_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random pop stalls, plus one long hold-off to fill the block.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) tracker.check_result(result);
      if (hold_off > 0) begin
        pop <= 1'b0;
        hold_off--;
      end else if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) pop_stall = $urandom_range(1, 6);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic offer(logic [31:0] t, bit en, int rx, int ry, int rz);
    gmd_pkg::in_t s;
    s.time_ms = t;
    s.enabled = en;
    s.rate_x = 16'(rx);
    s.rate_y = 16'(ry);
    s.rate_z = 16'(rz);
    push <= 1'b1;
    sample <= s;
    do @(posedge clk); while (full);
    tracker.note_sample(s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return $urandom_range(0, 1 << 16);
      2: return $urandom_range(0, 1 << 22);
      3: return $urandom_range(0, 1 << 28);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 400) - 200;
      2: return $urandom_range(0, 8000) - 4000;
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: now_ms = now_ms + $urandom;
        1: now_ms = now_ms + $urandom_range(1000, 6000);
        default: now_ms = now_ms + $urandom_range(0, 40);
      endcase
      offer(now_ms, $urandom_range(0, 7) != 0, pick_rate(), pick_rate(), pick_rate());
    end
  endtask

  task automatic set_all(logic [31:0] sens, logic [31:0] inv, logic [31:0] bind_sel,
                         logic [31:0] dz, logic [31:0] md, logic [31:0] dly);
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_INVERT_MASK, inv);
    write_reg(REG_BIND_MODE, bind_sel);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_MIN_STEP, md);
    write_reg(REG_DELAY_MS, dly);
  endtask

  initial begin
    tracker = new();
    tracker.reset_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset settings: no elapsed time, full-scale
    // rates, disabled samples, timestamp wrap, saturation and the zero vector.
    offer(32'd0, 1, 100, 100, 100);
    offer(32'd1, 1, 32767, -32768, 0);
    offer(32'd1001, 1, -32768, 32767, 1);
    offer(32'd2001, 0, 5, 5, 5);
    offer(32'hFFFF_FFF0, 1, 32767, 32767, -32768);
    offer(32'd5, 1, -1, 1, -32768);
    offer(32'd3005, 1, 32767, 32767, 32767);
    offer(32'd3006, 1, 100, -100, 50);
    offer(32'd3006, 1, 9, 9, 9);
    offer(32'd3040, 1, 0, 0, 0);
    offer(32'd3100, 1, 20000, -3000, -20000);
    drain();

    set_all(32'hFFFF, 32'd7, 32'd2, 32'd0, 32'h7FFF_FFFF, 32'd0);
    offer(32'd3200, 1, 1, -1, 0);
    offer(32'd3300, 1, 0, 0, 0);
    offer(32'd3400, 1, 32767, -32768, 32767);
    offer(32'd3500, 1, 3, 2, 1);
    drain();
    set_all(32'd0, 32'd0, 32'd3, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    offer(32'd3600, 1, 500, 500, 500);
    offer(32'd3700, 1, -500, 20, 5);
    drain();
    set_all(32'd256, 32'd5, 32'd1, 32'd0, 32'd0, 32'd10);
    offer(32'd3710, 1, 1000, 1000, 1000);
    offer(32'd3721, 1, 1000, 1000, 1000);
    offer(32'd3730, 1, 1000, -1000, 7);
    drain();
    now_ms = 32'd4000;

    for (int ph = 0; ph < 12; ph++) begin
      set_all($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(64, 1024),
              $urandom_range(0, 7), $urandom_range(0, 3), pick_q16(), pick_q16(),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 30) : 32'd0);
      if (ph == 3) hold_off = 800;
      if (ph >= 10) calm = 1;
      random_items(125);
      drain();
    end

    repeat (50) @(posedge clk);
    if (tracker.failures == 0 && tracker.due_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

/* gyro_motion_deadzone_unit.f */
+incdir+hw/rtl
hw/rtl/gmd_pkg.sv
hw/rtl/gmd_front.sv
hw/rtl/gmd_queue.sv
hw/rtl/gmd_back.sv
hw/rtl/gyro_motion_deadzone_unit.sv
tb/sv/testbench.sv
